@@ hdl/tkf_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, widths, register codes and the saturation helper.
// Used by tkf_mac, tkf_div and tilt_kalman_filter; no dependencies.
package tkf_pkg;

   // Fixed-point formats
   localparam int WORD_W        = 32;
   localparam int DT_FRAC_BITS  = 16;
   localparam int COV_FRAC_BITS = 24;

   // Item and register field widths
   localparam int ACCEL_W     = 25;
   localparam int GYRO_W      = 28;
   localparam int DT_W        = 16;
   localparam int CFG_W       = 25;
   localparam int REQ_TDATA_W = 72;
   localparam int CSR_INDEX_W = 4;

   // Datapath widths
   localparam int RATE_W  = 33;
   localparam int X_W     = 34;
   localparam int MAC_A_W = 34;
   localparam int MAC_B_W = 32;
   localparam int PROD_W  = MAC_A_W + MAC_B_W;
   localparam int RND_W   = 42;
   localparam int SAT_W   = RND_W + 1;

   // Divider
   localparam int DIV_STEPS = 32;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   // Register indexes on the csr port
   localparam logic [CSR_INDEX_W-1:0] CSR_INITIAL_ANGLE = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_ANGLE_NOISE   = CSR_INDEX_W'(1);
   localparam logic [CSR_INDEX_W-1:0] CSR_BIAS_NOISE    = CSR_INDEX_W'(2);
   localparam logic [CSR_INDEX_W-1:0] CSR_MEASURE_NOISE = CSR_INDEX_W'(3);

   // Reset values
   localparam logic signed [CFG_W-1:0] INIT_ANGLE_RESET = '0;
   localparam logic [CFG_W-1:0]        APN_RESET        = CFG_W'(16777);
   localparam logic [CFG_W-1:0]        BPN_RESET        = CFG_W'(50332);
   localparam logic [CFG_W-1:0]        MN_RESET         = CFG_W'(503316);
   localparam logic signed [WORD_W-1:0] COV_ONE = WORD_W'(1) << COV_FRAC_BITS;

   localparam logic signed [SAT_W-1:0] SAT_HI = (SAT_W'(1) << (WORD_W - 1)) - SAT_W'(1);
   localparam logic signed [SAT_W-1:0] SAT_LO = -(SAT_W'(1) << (WORD_W - 1));

   typedef enum logic [4:0] {
      ST_IDLE, ST_ANG, ST_T, ST_BB, ST_X, ST_AA, ST_AAW, ST_S, ST_DIV,
      ST_K0, ST_K1, ST_CBB, ST_CBA, ST_CAB, ST_CAA, ST_FIN, ST_OUT
   } tkf_state_type;

   typedef enum logic [1:0] {
      DV_IDLE, DV_RUN, DV_DONE
   } div_state_type;

   // Multiply-accumulate control: load captures a product; the flags ride along
   typedef struct packed {
      logic load;
      logic frac_cov;   // rescale by COV_FRAC_BITS, else by DT_FRAC_BITS
      logic subtract;   // base minus product, else base plus product
   } mac_ctl_type;

   typedef struct packed {
      logic                     done;
      logic signed [WORD_W-1:0] k0;
      logic signed [WORD_W-1:0] k1;
   } gain_type;

   function automatic logic signed [WORD_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
      logic signed [WORD_W-1:0] r;
      if (v > SAT_HI) begin
         r = SAT_HI[WORD_W-1:0];
      end else if (v < SAT_LO) begin
         r = SAT_LO[WORD_W-1:0];
      end else begin
         r = v[WORD_W-1:0];
      end
      return r;
   endfunction

endpackage

@@ hdl/tkf_mac.sv @@
`timescale 1ns / 1ps
// Shared multiply unit: registered product, round-half-up rescale,
// add or subtract onto a base word with saturation. Uses tkf_pkg.
module tkf_mac
   import tkf_pkg::*;
(
   input  logic                      clock,
   input  mac_ctl_type               ctl,
   input  logic signed [MAC_A_W-1:0] op_a,
   input  logic signed [MAC_B_W-1:0] op_b,
   input  logic signed [WORD_W-1:0]  base,
   output logic signed [RND_W-1:0]   rnd,
   output logic signed [WORD_W-1:0]  acc
);

   localparam logic signed [PROD_W-1:0] HALF_DT  = PROD_W'(1) << (DT_FRAC_BITS - 1);
   localparam logic signed [PROD_W-1:0] HALF_COV = PROD_W'(1) << (COV_FRAC_BITS - 1);

   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic                     frac_cov_ff;
   logic                     sub_ff;
   logic signed [PROD_W-1:0] sh_dt, sh_cov;
   logic signed [SAT_W-1:0]  acc_w;

   assign prod_in = op_a * op_b;

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         prod_ff     <= prod_in;
         frac_cov_ff <= ctl.frac_cov;
         sub_ff      <= ctl.subtract;
      end
   end

   // floor((p + half) / 2^n)
   assign sh_dt  = (prod_ff + HALF_DT) >>> DT_FRAC_BITS;
   assign sh_cov = (prod_ff + HALF_COV) >>> COV_FRAC_BITS;
   assign rnd    = frac_cov_ff ? sh_cov[RND_W-1:0] : sh_dt[RND_W-1:0];

   assign acc_w = sub_ff ? (SAT_W'(base) - SAT_W'(rnd)) : (SAT_W'(base) + SAT_W'(rnd));
   assign acc   = sat32(acc_w);

endmodule

@@ hdl/tkf_div.sv @@
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, two numerators over one
// shared positive divisor; gives saturated Q gains. Uses tkf_pkg.
module tkf_div
   import tkf_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [WORD_W-1:0]        divisor,
   input  logic signed [WORD_W-1:0] numer0,
   input  logic signed [WORD_W-1:0] numer1,
   output gain_type                 gain
);

   localparam logic [DIV_CNT_W-1:0] CNT_LAST = DIV_CNT_W'(DIV_STEPS - 1);

   div_state_type          state_ff, state_in;
   logic [DIV_CNT_W-1:0]   cnt_ff, cnt_in;
   logic [WORD_W-1:0]      div_ff, div_in;
   logic [WORD_W-1:0]      rem_ff [2];
   logic [WORD_W-1:0]      rem_in [2];
   logic [WORD_W-1:0]      quo_ff [2];
   logic [WORD_W-1:0]      quo_in [2];
   logic                   neg_ff [2];
   logic                   neg_in [2];
   logic                   ovf_ff [2];
   logic                   ovf_in [2];

   logic signed [WORD_W-1:0] num_w [2];
   logic [WORD_W-1:0]        mag_w [2];
   logic [WORD_W-1:0]        hi_w  [2];
   logic [WORD_W-1:0]        lo_w  [2];
   logic                     big_w [2];
   logic [WORD_W:0]          trial_w [2];
   logic signed [WORD_W-1:0] k_w [2];

   assign num_w[0] = numer0;
   assign num_w[1] = numer1;

   // Per-lane setup and trial subtract
   always_comb begin
      for (int l = 0; l < 2; l++) begin
         mag_w[l]   = num_w[l][WORD_W-1] ? (~num_w[l] + WORD_W'(1)) : num_w[l];
         hi_w[l]    = mag_w[l] >> (WORD_W - COV_FRAC_BITS);
         lo_w[l]    = mag_w[l] << COV_FRAC_BITS;
         big_w[l]   = (hi_w[l] >= divisor);   // quotient needs more than 32 bits
         trial_w[l] = {rem_ff[l], quo_ff[l][WORD_W-1]} - {1'b0, div_ff};
      end
   end

   // Saturated signed gains from magnitude quotients
   always_comb begin
      for (int l = 0; l < 2; l++) begin
         if (!neg_ff[l]) begin
            k_w[l] = (ovf_ff[l] || quo_ff[l][WORD_W-1]) ? SAT_HI[WORD_W-1:0] : quo_ff[l];
         end else if (ovf_ff[l] || (quo_ff[l][WORD_W-1] && (|quo_ff[l][WORD_W-2:0]))) begin
            k_w[l] = SAT_LO[WORD_W-1:0];
         end else begin
            k_w[l] = ~quo_ff[l] + WORD_W'(1);
         end
      end
   end

   assign gain.done = (state_ff == DV_DONE);
   assign gain.k0   = k_w[0];
   assign gain.k1   = k_w[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DV_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      div_ff <= div_in;
      for (int l = 0; l < 2; l++) begin
         rem_ff[l] <= rem_in[l];
         quo_ff[l] <= quo_in[l];
         neg_ff[l] <= neg_in[l];
         ovf_ff[l] <= ovf_in[l];
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      div_in   = div_ff;
      for (int l = 0; l < 2; l++) begin
         rem_in[l] = rem_ff[l];
         quo_in[l] = quo_ff[l];
         neg_in[l] = neg_ff[l];
         ovf_in[l] = ovf_ff[l];
      end
      unique case (state_ff)
         DV_IDLE: begin
            if (start) begin
               div_in = divisor;
               cnt_in = '0;
               for (int l = 0; l < 2; l++) begin
                  neg_in[l] = num_w[l][WORD_W-1];
                  ovf_in[l] = big_w[l];
                  rem_in[l] = big_w[l] ? '0 : hi_w[l];
                  quo_in[l] = lo_w[l];
               end
               state_in = DV_RUN;
            end
         end
         DV_RUN: begin
            for (int l = 0; l < 2; l++) begin
               if (!trial_w[l][WORD_W]) begin
                  rem_in[l] = trial_w[l][WORD_W-1:0];
               end else begin
                  rem_in[l] = {rem_ff[l][WORD_W-2:0], quo_ff[l][WORD_W-1]};
               end
               quo_in[l] = {quo_ff[l][WORD_W-2:0], ~trial_w[l][WORD_W]};
            end
            cnt_in = cnt_ff + DIV_CNT_W'(1);
            if (cnt_ff == CNT_LAST) begin
               state_in = DV_DONE;
            end
         end
         DV_DONE: begin
            state_in = DV_IDLE;
         end
         default: begin
            state_in = DV_IDLE;
         end
      endcase
   end

`ifndef SYNTH
   a_rem_below_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == DV_RUN) |-> ((rem_ff[0] < div_ff) && (rem_ff[1] < div_ff)))
      else $error("divider remainder not below divisor");
   a_done_after_run: assert property (@(posedge clock) disable iff (reset)
      (state_ff == DV_DONE) |-> ($past(state_ff) == DV_RUN))
      else $error("divider done without a run");
`endif

endmodule

@@ hdl/tilt_kalman_filter.sv @@
`timescale 1ns / 1ps
// Top level: two-state tilt/gyro-bias Kalman filter, state registers and
// sequencer. Depends on tkf_pkg, tkf_mac and tkf_div.
//
//  channel | dir | handshake             | payload
//  --------+-----+-----------------------+------------------------------------------
//  req     | in  | req_tvalid/req_tready | accel_tilt, gyro_omega, time_step
//  rsp     | out | rsp_tvalid/rsp_tready | angle_estimate
//  csr     | in  | csr_valid/csr_ready   | csr_index, csr_wdata (register write)
//
// An item passes through 7 prediction steps, the two-lane divider (one quotient bit per cycle,
// then done), 7 correction steps, the output step and the idle step, where the next item is
// accepted; with a non-positive innovation covariance the divider is skipped. All products
// share the one tkf_mac multiplier.
// Reset is synchronous; it restores registers and filter state. No clearing pass.
// A held result blocks nothing until the next one is done; that one waits in the output step.
module tilt_kalman_filter
   import tkf_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // item in
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // [24:0] accel_tilt, [52:25] gyro_omega,
                                               // [68:53] time_step, [71:69] zero
   // item out
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [WORD_W-1:0]      rsp_tdata,   // [31:0] angle_estimate
   // register writes
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]       csr_wdata
);

   // Field positions in req_tdata
   localparam int ACCEL_LSB = 0;
   localparam int GYRO_LSB  = ACCEL_LSB + ACCEL_W;
   localparam int DT_LSB    = GYRO_LSB + GYRO_W;

   tkf_state_type state_ff, state_in;

   // Registers
   logic signed [CFG_W-1:0] init_ff, init_in;
   logic [CFG_W-1:0]        apn_ff, apn_in;
   logic [CFG_W-1:0]        bpn_ff, bpn_in;
   logic [CFG_W-1:0]        mn_ff, mn_in;

   // Filter state
   logic signed [WORD_W-1:0] angle_ff, angle_in;
   logic signed [WORD_W-1:0] bias_ff, bias_in;
   logic signed [WORD_W-1:0] aa_ff, aa_in;
   logic signed [WORD_W-1:0] ab_ff, ab_in;
   logic signed [WORD_W-1:0] ba_ff, ba_in;
   logic signed [WORD_W-1:0] bb_ff, bb_in;

   // Per-item working registers
   logic signed [ACCEL_W-1:0] accel_ff, accel_in;
   logic [DT_W-1:0]           dt_ff, dt_in;
   logic signed [RATE_W-1:0]  rate_ff, rate_in;
   logic signed [WORD_W-1:0]  t_ff, t_in;
   logic signed [X_W-1:0]     x_ff, x_in;
   logic signed [WORD_W-1:0]  innov_ff, innov_in;
   logic signed [WORD_W-1:0]  k0_ff, k0_in;
   logic signed [WORD_W-1:0]  k1_ff, k1_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0]         rsp_data_ff, rsp_data_in;

   // Datapath nets
   logic signed [ACCEL_W-1:0] req_accel;
   logic signed [GYRO_W-1:0]  req_gyro;
   logic [DT_W-1:0]           req_dt;
   logic                      req_fire;
   logic                      csr_fire;

   mac_ctl_type               mac_ctl;
   logic signed [MAC_A_W-1:0] mac_a;
   logic signed [MAC_B_W-1:0] mac_b;
   logic signed [WORD_W-1:0]  mac_base;
   logic signed [RND_W-1:0]   mac_rnd;
   logic signed [WORD_W-1:0]  mac_acc;

   logic signed [WORD_W:0]    s_sum;
   logic                      s_pos;
   logic                      div_start;
   gain_type                  gain;

   logic signed [X_W-1:0]     apn_x;
   logic signed [X_W-1:0]     mn_x;
   logic signed [WORD_W:0]    ab_diff, ba_diff, innov_diff;

   assign req_accel = req_tdata[GYRO_LSB-1:ACCEL_LSB];
   assign req_gyro  = req_tdata[DT_LSB-1:GYRO_LSB];
   assign req_dt    = req_tdata[DT_LSB+DT_W-1:DT_LSB];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign csr_fire   = csr_valid && csr_ready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign apn_x = X_W'(apn_ff);
   assign mn_x  = X_W'(mn_ff);

   // Innovation covariance S = P00 + R; gains only when S is positive
   assign s_sum     = (WORD_W+1)'(aa_ff) + mn_x[WORD_W:0];
   assign s_pos     = !s_sum[WORD_W] && (s_sum != '0);
   assign div_start = (state_ff == ST_S) && s_pos;

   assign ab_diff    = (WORD_W+1)'(ab_ff) - (WORD_W+1)'(t_ff);
   assign ba_diff    = (WORD_W+1)'(ba_ff) - (WORD_W+1)'(t_ff);
   assign innov_diff = (WORD_W+1)'(accel_ff) - (WORD_W+1)'(angle_ff);

   tkf_mac u_mac (
      .clock (clock),
      .ctl   (mac_ctl),
      .op_a  (mac_a),
      .op_b  (mac_b),
      .base  (mac_base),
      .rnd   (mac_rnd),
      .acc   (mac_acc)
   );

   tkf_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .divisor (s_sum[WORD_W-1:0]),
      .numer0  (aa_ff),
      .numer1  (ba_ff),
      .gain    (gain)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         init_ff      <= INIT_ANGLE_RESET;
         apn_ff       <= APN_RESET;
         bpn_ff       <= BPN_RESET;
         mn_ff        <= MN_RESET;
         angle_ff     <= WORD_W'(INIT_ANGLE_RESET);
         bias_ff      <= '0;
         aa_ff        <= COV_ONE;
         ab_ff        <= '0;
         ba_ff        <= '0;
         bb_ff        <= COV_ONE;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         init_ff      <= init_in;
         apn_ff       <= apn_in;
         bpn_ff       <= bpn_in;
         mn_ff        <= mn_in;
         angle_ff     <= angle_in;
         bias_ff      <= bias_in;
         aa_ff        <= aa_in;
         ab_ff        <= ab_in;
         ba_ff        <= ba_in;
         bb_ff        <= bb_in;
      end
   end

   always_ff @(posedge clock) begin
      accel_ff    <= accel_in;
      dt_ff       <= dt_in;
      rate_ff     <= rate_in;
      t_ff        <= t_in;
      x_ff        <= x_in;
      innov_ff    <= innov_in;
      k0_ff       <= k0_in;
      k1_ff       <= k1_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      init_in      = init_ff;
      apn_in       = apn_ff;
      bpn_in       = bpn_ff;
      mn_in        = mn_ff;
      angle_in     = angle_ff;
      bias_in      = bias_ff;
      aa_in        = aa_ff;
      ab_in        = ab_ff;
      ba_in        = ba_ff;
      bb_in        = bb_ff;
      accel_in     = accel_ff;
      dt_in        = dt_ff;
      rate_in      = rate_ff;
      t_in         = t_ff;
      x_in         = x_ff;
      innov_in     = innov_ff;
      k0_in        = k0_ff;
      k1_in        = k1_ff;
      mac_ctl      = '0;
      mac_a        = '0;
      mac_b        = MAC_B_W'(dt_ff);
      mac_base     = angle_ff;

      // Users keep register writes to idle, unenforced; initial angle also sets the estimate
      if (csr_fire) begin
         unique case (csr_index)
            CSR_INITIAL_ANGLE: begin
               init_in  = csr_wdata;
               angle_in = WORD_W'($signed(csr_wdata));
            end
            CSR_ANGLE_NOISE:   apn_in = csr_wdata;
            CSR_BIAS_NOISE:    bpn_in = csr_wdata;
            CSR_MEASURE_NOISE: mn_in  = csr_wdata;
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               accel_in = req_accel;
               dt_in    = req_dt;
               rate_in  = RATE_W'(req_gyro) - RATE_W'(bias_ff);
               state_in = ST_ANG;
            end
         end
         // predict: angle += dt * (rate - bias)
         ST_ANG: begin
            mac_ctl  = '{load: 1'b1, frac_cov: 1'b0, subtract: 1'b0};
            mac_a    = MAC_A_W'(rate_ff);
            state_in = ST_T;
         end
         ST_T: begin
            mac_base = angle_ff;
            angle_in = mac_acc;
            mac_ctl  = '{load: 1'b1, frac_cov: 1'b0, subtract: 1'b0};
            mac_a    = MAC_A_W'(bb_ff);
            state_in = ST_BB;
         end
         ST_BB: begin
            t_in     = mac_rnd[WORD_W-1:0];
            mac_ctl  = '{load: 1'b1, frac_cov: 1'b0, subtract: 1'b0};
            mac_a    = MAC_A_W'(bpn_ff);
            state_in = ST_X;
         end
         // x uses the old off-diagonals, which update in the same cycle
         ST_X: begin
            mac_base = bb_ff;
            bb_in    = mac_acc;
            x_in     = X_W'(t_ff) - X_W'(ab_ff) - X_W'(ba_ff) + apn_x;
            ab_in    = sat32(SAT_W'(ab_diff));
            ba_in    = sat32(SAT_W'(ba_diff));
            state_in = ST_AA;
         end
         ST_AA: begin
            mac_ctl  = '{load: 1'b1, frac_cov: 1'b0, subtract: 1'b0};
            mac_a    = x_ff;
            state_in = ST_AAW;
         end
         ST_AAW: begin
            mac_base = aa_ff;
            aa_in    = mac_acc;
            innov_in = sat32(SAT_W'(innov_diff));
            state_in = ST_S;
         end
         ST_S: begin
            if (s_pos) begin
               state_in = ST_DIV;
            end else begin
               k0_in    = '0;
               k1_in    = '0;
               state_in = ST_K0;
            end
         end
         ST_DIV: begin
            if (gain.done) begin
               k0_in    = gain.k0;
               k1_in    = gain.k1;
               state_in = ST_K0;
            end
         end
         // correct: each covariance term is written after its last use
         ST_K0: begin
            mac_ctl  = '{load: 1'b1, frac_cov: 1'b1, subtract: 1'b0};
            mac_a    = MAC_A_W'(innov_ff);
            mac_b    = k0_ff;
            state_in = ST_K1;
         end
         ST_K1: begin
            mac_base = angle_ff;
            angle_in = mac_acc;
            mac_ctl  = '{load: 1'b1, frac_cov: 1'b1, subtract: 1'b0};
            mac_a    = MAC_A_W'(innov_ff);
            mac_b    = k1_ff;
            state_in = ST_CBB;
         end
         ST_CBB: begin
            mac_base = bias_ff;
            bias_in  = mac_acc;
            mac_ctl  = '{load: 1'b1, frac_cov: 1'b1, subtract: 1'b1};
            mac_a    = MAC_A_W'(ab_ff);
            mac_b    = k1_ff;
            state_in = ST_CBA;
         end
         ST_CBA: begin
            mac_base = bb_ff;
            bb_in    = mac_acc;
            mac_ctl  = '{load: 1'b1, frac_cov: 1'b1, subtract: 1'b1};
            mac_a    = MAC_A_W'(aa_ff);
            mac_b    = k1_ff;
            state_in = ST_CAB;
         end
         ST_CAB: begin
            mac_base = ba_ff;
            ba_in    = mac_acc;
            mac_ctl  = '{load: 1'b1, frac_cov: 1'b1, subtract: 1'b1};
            mac_a    = MAC_A_W'(ab_ff);
            mac_b    = k0_ff;
            state_in = ST_CAA;
         end
         ST_CAA: begin
            mac_base = ab_ff;
            ab_in    = mac_acc;
            mac_ctl  = '{load: 1'b1, frac_cov: 1'b1, subtract: 1'b1};
            mac_a    = MAC_A_W'(aa_ff);
            mac_b    = k0_ff;
            state_in = ST_FIN;
         end
         ST_FIN: begin
            mac_base = aa_ff;
            aa_in    = mac_acc;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = angle_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

`ifndef SYNTH
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_tready)
      else $error("item accepted while the previous one is in work");
   a_gain_from_divider: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_K0) && ($past(state_ff) == ST_DIV)) |-> $past(gain.done))
      else $error("correction started before the gains were ready");
   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_OUT) && (!rsp_valid_ff || rsp_tready))
         |=> (rsp_tvalid && (rsp_tdata == $past(angle_ff))))
      else $error("result not presented after the output step");
`endif

endmodule
